@@ rtl/gsc_pkg.sv @@
// gsc_pkg: types, codes and constants of the gantry stepper command sequencer
// used by gsc_cmd_queue and gantry_stepper_command_sequencer; no dependencies
package gsc_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int QUEUED_W    = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MOVE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_UP_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_LEFT_TICKS = 2'd2;

    localparam logic [CFG_W-1:0] TICKS_PER_MOVE_RST  = 16'd1103;
    localparam logic [CFG_W-1:0] HOME_UP_TICKS_RST   = 16'd2905;
    localparam logic [CFG_W-1:0] HOME_LEFT_TICKS_RST = 16'd1637;

    localparam logic [7:0] BYTE_START = 8'h61;
    localparam logic [7:0] DIR_BASE   = 8'd48;
    localparam logic [7:0] DIR_LAST   = 8'd51;
    localparam logic [7:0] SOL_ON     = 8'd1;

    // bit 0 left motor, bit 1 right motor, 1 = phase counts up
    localparam logic [1:0] SENSE_UP    = 2'd2;
    localparam logic [1:0] SENSE_RIGHT = 2'd0;
    localparam logic [1:0] SENSE_DOWN  = 2'd1;
    localparam logic [1:0] SENSE_LEFT  = 2'd3;

    typedef enum logic [1:0] {
        KIND_BYTE        = 2'd0,
        KIND_TICK        = 2'd1,
        KIND_DOWN_LIMIT  = 2'd2,
        KIND_RIGHT_LIMIT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAGE_DOWN  = 3'd0,
        STAGE_RIGHT = 3'd1,
        STAGE_UP    = 3'd2,
        STAGE_LEFT  = 3'd3,
        STAGE_DONE  = 3'd4
    } stage_t;

    typedef logic [2:0]      cmd_t;
    typedef logic [Q_CW-1:0] fill_t;

    typedef struct packed {
        logic push;
        logic pop;
        cmd_t cmd;
    } q_ctrl_t;

    typedef struct packed {
        logic  full;
        fill_t fill;
        cmd_t  head_cmd;
    } q_stat_t;

    function automatic logic [3:0] coil_of(input logic [2:0] phase);
        logic [3:0] c;
        case (phase)
            3'd0:    c = 4'h1;
            3'd1:    c = 4'h5;
            3'd2:    c = 4'h4;
            3'd3:    c = 4'h6;
            3'd4:    c = 4'h2;
            3'd5:    c = 4'hA;
            3'd6:    c = 4'h8;
            default: c = 4'h9;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] sense_of_dir(input logic [1:0] dir);
        logic [1:0] s;
        case (dir)
            2'd0:    s = SENSE_UP;
            2'd1:    s = SENSE_RIGHT;
            2'd2:    s = SENSE_DOWN;
            default: s = SENSE_LEFT;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/gsc_cmd_queue.sv @@
// gsc_cmd_queue: command fifo with same-cycle head read and empty bypass
// depends on gsc_pkg
module gsc_cmd_queue
    import gsc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  q_ctrl_t ctrl,
    output q_stat_t stat
);

    cmd_t             store_reg [QUEUE_DEPTH];
    logic [Q_AW-1:0]  head_reg, head_next;
    logic [Q_AW-1:0]  tail_reg, tail_next;
    fill_t            fill_reg, fill_next;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (ctrl.push) begin
            tail_next = (tail_reg == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (ctrl.pop) begin
            head_next = (head_reg == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (!ctrl.push && ctrl.pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            store_reg[tail_reg] <= ctrl.cmd;
        end
    end

    // empty queue: the command being pushed is the head
    assign stat.full     = (fill_reg == Q_CW'(QUEUE_DEPTH));
    assign stat.fill     = fill_reg;
    assign stat.head_cmd = (fill_reg == '0) ? ctrl.cmd : store_reg[head_reg];

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= Q_CW'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_pop_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |-> (fill_reg != '0) || ctrl.push)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.push && stat.full) |-> ctrl.pop == 1'b0 && 1'b0)
        else $error("push into full queue");

endmodule

@@ rtl/gantry_stepper_command_sequencer.sv @@
// gantry_stepper_command_sequencer: top level, framing, homing and move sequencing
// depends on gsc_pkg and gsc_cmd_queue
//
// s_ channel: one item per handshake, s_kind selects serial byte, step tick,
// down limit or right limit; s_rx_byte is used only for serial bytes.
// m_ channel: exactly one result item per input item, in order, giving the
// coil patterns of both motors, solenoid, moving, homed, queue fill and a
// flag for a command lost to a full queue.
// cfg_ port: single-cycle writes of ticks_per_move, home_up_ticks and
// home_left_ticks; they apply at the next load of the tick counter.
// Output: the result of an item is registered when it is accepted and is on m_ in the next cycle.
// Throughput: one item per cycle while m_valid is low or m_ready is high;
// all work is one pass of logic from the state registers to the result register.
// Reset: homing starts at once, moving down until the down limit, then right
// until the right limit, then up and left for the configured tick counts.
// Stall: the result register holds while m_ready is low; s_ready stays high
// as long as the result register is empty or being emptied in that cycle.
module gantry_stepper_command_sequencer
    import gsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_kind,
    input  logic [7:0]           s_rx_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_left_coils,
    output logic [3:0]           m_right_coils,
    output logic                 m_solenoid_on,
    output logic                 m_moving,
    output logic                 m_homed,
    output logic [QUEUED_W-1:0]  m_queued,
    output logic                 m_command_dropped,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic             s_accept;
    logic [CFG_W-1:0] ticks_per_move_reg, home_up_ticks_reg, home_left_ticks_reg;

    logic [7:0]       fb0_reg, fb0_next, fb1_reg, fb1_next;
    logic [1:0]       fc_reg, fc_next;
    logic             push_req, push_ok, dropped;
    cmd_t             push_cmd;

    stage_t           stage_reg, stage_next;
    logic             busy_reg, busy_next;
    logic [1:0]       sense_reg, sense_next;
    logic [CFG_W-1:0] tr_reg, tr_next;
    logic [2:0]       lp_reg, lp_next, rp_reg, rp_next;
    logic             sol_reg, sol_next;
    logic             pop;

    q_ctrl_t          q_ctrl;
    q_stat_t          q_stat;
    fill_t            fill_next;

    logic                m_valid_reg;
    logic [3:0]          m_left_coils_reg, m_left_coils_next;
    logic [3:0]          m_right_coils_reg, m_right_coils_next;
    logic                m_solenoid_on_reg, m_moving_reg, m_homed_reg, m_homed_next;
    logic [QUEUED_W-1:0] m_queued_reg, m_queued_next;
    logic                m_command_dropped_reg;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_per_move_reg  <= TICKS_PER_MOVE_RST;
            home_up_ticks_reg   <= HOME_UP_TICKS_RST;
            home_left_ticks_reg <= HOME_LEFT_TICKS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TICKS_PER_MOVE:  ticks_per_move_reg  <= cfg_wdata;
                CFG_HOME_UP_TICKS:   home_up_ticks_reg   <= cfg_wdata;
                CFG_HOME_LEFT_TICKS: home_left_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // byte framing
    always_comb begin
        fb0_next = fb0_reg;
        fb1_next = fb1_reg;
        fc_next  = fc_reg;
        push_req = 1'b0;
        push_cmd = '0;
        if (s_accept && kind_t'(s_kind) == KIND_BYTE) begin
            if (fc_reg == 2'd0) begin
                fb0_next = s_rx_byte;
                fc_next  = 2'd1;
            end else if (fc_reg == 2'd1) begin
                fb1_next = s_rx_byte;
                fc_next  = 2'd2;
            end else if (fb0_reg == BYTE_START) begin
                if (fb1_reg >= DIR_BASE && fb1_reg <= DIR_LAST) begin
                    push_req = 1'b1;
                    push_cmd = {s_rx_byte == SOL_ON, fb1_reg[1:0]};
                end
                fc_next  = 2'd0;
                fb0_next = '0;
                fb1_next = '0;
            end else begin
                fb0_next = fb1_reg;
                fb1_next = s_rx_byte;
                fc_next  = 2'd2;
            end
        end
    end

    assign push_ok = push_req && !q_stat.full;
    assign dropped = push_req && q_stat.full;

    // motion and homing next state
    always_comb begin
        stage_next = stage_reg;
        busy_next  = busy_reg;
        sense_next = sense_reg;
        tr_next    = tr_reg;
        lp_next    = lp_reg;
        rp_next    = rp_reg;
        sol_next   = sol_reg;
        pop        = 1'b0;
        if (s_accept) begin
            case (kind_t'(s_kind))
                KIND_TICK: begin
                    if (busy_reg) begin
                        lp_next = lp_reg + (sense_reg[0] ? 3'd1 : 3'd7);
                        rp_next = rp_reg + (sense_reg[1] ? 3'd1 : 3'd7);
                        if (stage_reg != STAGE_DOWN && stage_reg != STAGE_RIGHT) begin
                            if (tr_reg != '0) begin
                                tr_next = tr_reg - 1'b1;
                            end
                            if (tr_next == '0) begin
                                busy_next = 1'b0;
                            end
                        end
                    end
                end
                KIND_DOWN_LIMIT: begin
                    if (stage_reg == STAGE_DOWN) begin
                        stage_next = STAGE_RIGHT;
                        sense_next = SENSE_RIGHT;
                        busy_next  = 1'b1;
                    end
                end
                KIND_RIGHT_LIMIT: begin
                    if (stage_reg == STAGE_RIGHT) begin
                        stage_next = STAGE_UP;
                        sense_next = SENSE_UP;
                        tr_next    = home_up_ticks_reg;
                        busy_next  = (home_up_ticks_reg != '0);
                    end
                end
                default: ;
            endcase
            if (stage_next == STAGE_UP && !busy_next) begin
                stage_next = STAGE_LEFT;
                sense_next = SENSE_LEFT;
                tr_next    = home_left_ticks_reg;
                busy_next  = (home_left_ticks_reg != '0);
            end
            if (stage_next == STAGE_LEFT && !busy_next) begin
                stage_next = STAGE_DONE;
            end
            if (stage_next == STAGE_DONE && !busy_next
                    && (q_stat.fill != '0 || push_ok)) begin
                pop        = 1'b1;
                sol_next   = q_stat.head_cmd[2];
                sense_next = sense_of_dir(q_stat.head_cmd[1:0]);
                tr_next    = ticks_per_move_reg;
                busy_next  = (ticks_per_move_reg != '0);
            end
        end
    end

    assign q_ctrl.push = push_ok;
    assign q_ctrl.pop  = pop;
    assign q_ctrl.cmd  = push_cmd;

    gsc_cmd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (q_ctrl),
        .stat    (q_stat)
    );

    // result item contents
    always_comb begin
        fill_next = q_stat.fill;
        if (push_ok && !pop) begin
            fill_next = q_stat.fill + 1'b1;
        end else if (!push_ok && pop) begin
            fill_next = q_stat.fill - 1'b1;
        end
        m_left_coils_next  = coil_of(lp_next);
        m_right_coils_next = coil_of(rp_next);
        m_homed_next       = (stage_next == STAGE_DONE);
        m_queued_next      = QUEUED_W'(fill_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb0_reg     <= '0;
            fb1_reg     <= '0;
            fc_reg      <= '0;
            stage_reg   <= STAGE_DOWN;
            busy_reg    <= 1'b1;
            sense_reg   <= SENSE_DOWN;
            tr_reg      <= '0;
            lp_reg      <= '0;
            rp_reg      <= '0;
            sol_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fb0_reg   <= fb0_next;
            fb1_reg   <= fb1_next;
            fc_reg    <= fc_next;
            stage_reg <= stage_next;
            busy_reg  <= busy_next;
            sense_reg <= sense_next;
            tr_reg    <= tr_next;
            lp_reg    <= lp_next;
            rp_reg    <= rp_next;
            sol_reg   <= sol_next;
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_left_coils_reg      <= m_left_coils_next;
            m_right_coils_reg     <= m_right_coils_next;
            m_solenoid_on_reg     <= sol_next;
            m_moving_reg          <= busy_next;
            m_homed_reg           <= m_homed_next;
            m_queued_reg          <= m_queued_next;
            m_command_dropped_reg <= dropped;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_left_coils      = m_left_coils_reg;
    assign m_right_coils     = m_right_coils_reg;
    assign m_solenoid_on     = m_solenoid_on_reg;
    assign m_moving          = m_moving_reg;
    assign m_homed           = m_homed_reg;
    assign m_queued          = m_queued_reg;
    assign m_command_dropped = m_command_dropped_reg;

    a_seek_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_reg == STAGE_DOWN || stage_reg == STAGE_RIGHT) |-> busy_reg)
        else $error("idle during limit seek");

    a_homed_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_reg == STAGE_DONE |=> stage_reg == STAGE_DONE)
        else $error("left homed state");

    a_tick_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && kind_t'(s_kind) == KIND_TICK && busy_reg)
            |=> lp_reg != $past(lp_reg) && rp_reg != $past(rp_reg))
        else $error("tick while moving did not step");

endmodule
